/* rtl/ndg_pkg.sv */
// Shared types and constants of the note dispenser.
package ndg_pkg;

    localparam int NUM_DENOM = 8;
    localparam int AMOUNT_W  = 20;
    localparam int REM_W     = 18;
    localparam int STOCK_W   = 14;
    localparam int BAL_W     = 18;
    localparam int IN_W      = 24;
    localparam int OUT_W     = 104;

    localparam int unsigned DENOM_VALUE [NUM_DENOM] =
        '{500, 150, 50, 20, 10, 5, 2, 1};
    localparam int unsigned STOCK_RESET [NUM_DENOM] =
        '{100, 200, 400, 800, 1600, 3200, 6400, 12800};

    localparam logic [BAL_W-1:0] BALANCE_RESET = BAL_W'(173600);

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_INSUF  = 2'd1,
        STATUS_NO_PAY = 2'd2
    } status_t;

    // remaining amount handed from one cell to the next
    typedef struct packed {
        logic             valid;
        logic [REM_W-1:0] rem;
    } cell_link_t;

endpackage

/* rtl/ndg_cell.sv */
// One denomination cell: holds its stock, takes notes from the passing remainder.
module ndg_cell #(
    parameter int unsigned DENOM       = 500,
    parameter int unsigned RESET_STOCK = 100
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ndg_pkg::cell_link_t                  link_in,
    output ndg_pkg::cell_link_t                  link_out,
    input  logic                                 commit,
    output logic [ndg_pkg::STOCK_W-1:0]          take
);

    localparam int REM_W   = ndg_pkg::REM_W;
    localparam int STOCK_W = ndg_pkg::STOCK_W;
    localparam int SHIFT   = 24;
    localparam int RECIP_W = SHIFT + 1;
    localparam int PROD_W  = REM_W + RECIP_W;
    localparam int unsigned RECIP = (32'd1 << SHIFT) / DENOM;

    logic               v1_reg;
    logic [REM_W-1:0]   r1_reg;
    logic [REM_W-1:0]   q0_reg;
    logic               v2_reg;
    logic [REM_W-1:0]   rem_out_reg, rem_out_next;
    logic [STOCK_W-1:0] take_reg, take_next;
    logic [STOCK_W-1:0] stock_reg;

    logic [PROD_W-1:0]  prod;
    logic [REM_W-1:0]   rem0;
    logic               fix;
    logic [REM_W-1:0]   q;
    logic [REM_W-1:0]   rmod;
    logic [REM_W-1:0]   cap;

    // quotient estimate by reciprocal, low by at most one
    assign prod = PROD_W'(link_in.rem) * PROD_W'(RECIP);

    always_comb
    begin
        rem0 = r1_reg - REM_W'(q0_reg * REM_W'(DENOM));
        fix  = (rem0 >= REM_W'(DENOM));
        q    = q0_reg + REM_W'(fix);
        rmod = fix ? (rem0 - REM_W'(DENOM)) : rem0;
        cap  = REM_W'(REM_W'(stock_reg) * REM_W'(DENOM));
        if (q >= REM_W'(stock_reg))
        begin
            take_next    = stock_reg;
            rem_out_next = r1_reg - cap;
        end
        else
        begin
            take_next    = q[STOCK_W-1:0];
            rem_out_next = rmod;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            stock_reg <= STOCK_W'(RESET_STOCK);
        end
        else
        begin
            v1_reg <= link_in.valid;
            v2_reg <= v1_reg;
            if (commit)
                stock_reg <= stock_reg - take_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_in.valid)
        begin
            r1_reg <= link_in.rem;
            q0_reg <= REM_W'(prod >> SHIFT);
        end
        if (v1_reg)
        begin
            rem_out_reg <= rem_out_next;
            take_reg    <= take_next;
        end
    end

    assign link_out.valid = v2_reg;
    assign link_out.rem   = rem_out_reg;
    assign take           = take_reg;

endmodule

/* rtl/note_dispense_greedy.sv */
// Note dispenser top level: request control, cell chain and result register.
//
//  channel | dir | tdata fields (lsb first)                          | tuser/tlast
//  s_axis  | in  | amount[19:0], zero pad to 24                      | none
//  m_axis  | out | status, count_500..count_1, balance_after (104 b) | none
//
//  A request runs through eight denomination cells, each registering a
//  reciprocal multiply, then a correction and take; a request over the
//  balance skips the chain and goes straight to the result.
//  One request is in work at a time; the next beat is taken while a result waits.
//  Reset loads the stock of every denomination; no clearing pass.
//  A stalled result holds its beat; completion waits for the result register.
module note_dispense_greedy (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [ndg_pkg::IN_W-1:0]   s_tdata,   // amount[19:0]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [ndg_pkg::OUT_W-1:0]  m_tdata    // status, count_500, count_150, count_50,
                                                  // count_20, count_10, count_5, count_2,
                                                  // count_1, balance_after
);

    localparam int N       = ndg_pkg::NUM_DENOM;
    localparam int STOCK_W = ndg_pkg::STOCK_W;
    localparam int BAL_W   = ndg_pkg::BAL_W;
    localparam int REM_W   = ndg_pkg::REM_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t                       state_reg, state_next;
    ndg_pkg::status_t             status_reg, status_next;
    logic [ndg_pkg::AMOUNT_W-1:0] amount_reg;
    logic [BAL_W-1:0]             balance_reg, balance_next;
    logic                         out_valid_reg;
    logic [ndg_pkg::OUT_W-1:0]    out_data_reg, out_data_next;

    ndg_pkg::cell_link_t          link [N+1];
    logic [STOCK_W-1:0]           take [N];
    logic                         commit;
    logic                         accept;
    logic                         finish;
    logic                         insuf;
    logic [STOCK_W-1:0]           cnt [N];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign insuf    = (s_tdata[ndg_pkg::AMOUNT_W-1:0] >
                       ndg_pkg::AMOUNT_W'(balance_reg));
    assign finish   = (state_reg == ST_FIN) && (!out_valid_reg || m_tready);
    assign commit   = finish && (status_reg == ndg_pkg::STATUS_OK);

    assign link[0].valid = accept && !insuf;
    assign link[0].rem   = s_tdata[REM_W-1:0];

    for (genvar k = 0; k < N; k++)
    begin : g_cell
        ndg_cell #(
            .DENOM       (ndg_pkg::DENOM_VALUE[k]),
            .RESET_STOCK (ndg_pkg::STOCK_RESET[k])
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .link_in  (link[k]),
            .link_out (link[k+1]),
            .commit   (commit),
            .take     (take[k])
        );
        assign cnt[k] = (status_reg == ndg_pkg::STATUS_OK) ? take[k] : '0;
    end

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next  = insuf ? ST_FIN : ST_RUN;
                    status_next = insuf ? ndg_pkg::STATUS_INSUF : ndg_pkg::STATUS_OK;
                end
            end
            ST_RUN:
            begin
                if (link[N].valid)
                begin
                    state_next  = ST_FIN;
                    status_next = (link[N].rem == '0) ? ndg_pkg::STATUS_OK
                                                      : ndg_pkg::STATUS_NO_PAY;
                end
            end
            ST_FIN:
            begin
                if (finish)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // on success the notes taken add up to the amount
    assign balance_next = (status_reg == ndg_pkg::STATUS_OK)
                        ? balance_reg - amount_reg[BAL_W-1:0] : balance_reg;

    assign out_data_next = {balance_next,
                            cnt[7][13:0], cnt[6][12:0], cnt[5][11:0], cnt[4][10:0],
                            cnt[3][9:0],  cnt[2][8:0],  cnt[1][7:0],  cnt[0][6:0],
                            status_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            status_reg    <= ndg_pkg::STATUS_OK;
            balance_reg   <= ndg_pkg::BALANCE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            if (finish)
            begin
                balance_reg   <= balance_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            amount_reg <= s_tdata[ndg_pkg::AMOUNT_W-1:0];
        if (finish)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_bal_bound: assert property (@(posedge clk) disable iff (!rst_n)
        balance_reg <= ndg_pkg::BALANCE_RESET)
        else $error("balance above initial stock value");

    a_chain_end_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        link[N].valid |-> state_reg == ST_RUN)
        else $error("chain result outside run state");

    a_commit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> balance_reg >= amount_reg[BAL_W-1:0])
        else $error("commit would underflow balance");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != ST_IDLE)
        else $error("accepted beat left block idle");

endmodule

/* tb/sv/tb_note_dispense_greedy.sv */
// Self-checking testbench for the note dispenser: stream stimulus, payout prediction, result check.
module tb_note_dispense_greedy;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CNT_W [ndg_pkg::NUM_DENOM] = '{7, 8, 9, 10, 11, 12, 13, 14};
    localparam int QUIET_LO = 3000;
    localparam int QUIET_HI = 9000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        int unsigned n [ndg_pkg::NUM_DENOM];
    } vault_t;

    typedef struct {
        ndg_pkg::status_t            status;
        logic [ndg_pkg::STOCK_W-1:0] cnt [ndg_pkg::NUM_DENOM];
        logic [ndg_pkg::BAL_W-1:0]   balance;
    } payout_t;

    typedef struct {
        logic [ndg_pkg::AMOUNT_W-1:0] amount;
        bit                           hold;   // wait for all payouts before sending
    } request_t;

    logic                       clk;
    logic                       rst_n    = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [ndg_pkg::IN_W-1:0]   s_tdata  = '0;   // amount[19:0], zero pad
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [ndg_pkg::OUT_W-1:0]  m_tdata;         // status, count_500 .. count_1, balance_after

    request_t request_q [$];
    payout_t  payout_q [$];
    vault_t   live_vault;
    vault_t   plan_vault;
    int       n_fail = 0;
    int       cyc = 0;

    note_dispense_greedy DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
    end

    function automatic int unsigned vault_value(input vault_t v);
        int unsigned sum;
        sum = 0;
        for (int k = 0; k < ndg_pkg::NUM_DENOM; k++)
            sum += ndg_pkg::DENOM_VALUE[k] * v.n[k];
        return sum;
    endfunction

    function automatic vault_t full_vault();
        vault_t v;
        for (int k = 0; k < ndg_pkg::NUM_DENOM; k++)
            v.n[k] = ndg_pkg::STOCK_RESET[k];
        return v;
    endfunction

    // Greedy pick, largest note first; all-or-nothing on the stock.
    function automatic payout_t dispense(input logic [ndg_pkg::AMOUNT_W-1:0] amount,
                                         input vault_t cur, output vault_t nxt);
        payout_t     p;
        int unsigned rem;
        int unsigned want;
        int unsigned take [ndg_pkg::NUM_DENOM];
        nxt = cur;
        p.status = ndg_pkg::STATUS_OK;
        rem = 32'(amount);
        for (int k = 0; k < ndg_pkg::NUM_DENOM; k++)
            take[k] = 0;
        if (32'(amount) > vault_value(cur))
            p.status = ndg_pkg::STATUS_INSUF;
        else
        begin
            for (int k = 0; k < ndg_pkg::NUM_DENOM; k++)
            begin
                want = rem / ndg_pkg::DENOM_VALUE[k];
                take[k] = (want < cur.n[k]) ? want : cur.n[k];
                rem -= take[k] * ndg_pkg::DENOM_VALUE[k];
            end
            if (rem != 0)
            begin
                p.status = ndg_pkg::STATUS_NO_PAY;
                for (int k = 0; k < ndg_pkg::NUM_DENOM; k++)
                    take[k] = 0;
            end
            else
                for (int k = 0; k < ndg_pkg::NUM_DENOM; k++)
                    nxt.n[k] = cur.n[k] - take[k];
        end
        for (int k = 0; k < ndg_pkg::NUM_DENOM; k++)
            p.cnt[k] = ndg_pkg::STOCK_W'(take[k]);
        p.balance = ndg_pkg::BAL_W'(vault_value(nxt));
        return p;
    endfunction

    function automatic payout_t unpack_beat(input logic [ndg_pkg::OUT_W-1:0] d);
        payout_t p;
        int      off;
        p.status = ndg_pkg::status_t'(d[1:0]);
        off = 2;
        for (int k = 0; k < ndg_pkg::NUM_DENOM; k++)
        begin
            p.cnt[k] = ndg_pkg::STOCK_W'((d >> off)
                       & ((ndg_pkg::OUT_W'(1) << CNT_W[k]) - 1));
            off += CNT_W[k];
        end
        p.balance = d[off +: ndg_pkg::BAL_W];
        return p;
    endfunction

    function automatic bit take_break();
        if (cyc >= QUIET_LO && cyc < QUIET_HI)
            return 1'b0;
        return $urandom_range(99) < 20;
    endfunction

    // Queue a request and track the stock it leaves, so later amounts can follow the balance.
    task automatic queue_request(input logic [ndg_pkg::AMOUNT_W-1:0] amt, input bit hold);
        request_t r;
        void'(dispense(amt, plan_vault, plan_vault));
        r.amount = amt;
        r.hold = hold;
        request_q.push_back(r);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            request_t nx;
            if (s_tvalid && s_tready)
                payout_q.push_back(dispense(s_tdata[ndg_pkg::AMOUNT_W-1:0],
                                            live_vault, live_vault));
            if (!s_tvalid || s_tready)
            begin
                if (request_q.size() != 0 && !(request_q[0].hold && payout_q.size() != 0)
                    && !take_break())
                begin
                    nx = request_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= ndg_pkg::IN_W'(nx.amount);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            payout_t act;
            payout_t exp;
            if (m_tvalid && m_tready)
            begin
                act = unpack_beat(m_tdata);
                if (payout_q.size() == 0)
                begin
                    $error("unexpected result beat %h", m_tdata);
                    n_fail++;
                end
                else
                begin
                    exp = payout_q.pop_front();
                    if (act.status != exp.status)
                    begin
                        $error("status expected %0d got %0d", exp.status, act.status);
                        n_fail++;
                    end
                    for (int k = 0; k < ndg_pkg::NUM_DENOM; k++)
                        if (act.cnt[k] != exp.cnt[k])
                        begin
                            $error("count_%0d expected %0d got %0d",
                                   ndg_pkg::DENOM_VALUE[k], exp.cnt[k], act.cnt[k]);
                            n_fail++;
                        end
                    if (act.balance != exp.balance)
                    begin
                        $error("balance_after expected %0d got %0d", exp.balance, act.balance);
                        n_fail++;
                    end
                end
            end
            m_tready <= !take_break();
        end
    end

    initial
    begin
        #3ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int          r;
        int unsigned bal;
        live_vault = full_vault();
        plan_vault = full_vault();

        // directed: zero, odd remainders, note edges, out-of-balance amounts
        queue_request(20'd0, 1'b0);
        queue_request(20'd1, 1'b0);
        queue_request(20'd2, 1'b0);
        queue_request(20'd3, 1'b0);
        queue_request(20'd4, 1'b0);
        queue_request(20'd5, 1'b0);
        queue_request(20'd6, 1'b0);
        queue_request(20'd7, 1'b0);
        queue_request(20'd9, 1'b0);
        queue_request(20'd19, 1'b0);
        queue_request(20'd49, 1'b0);
        queue_request(20'd149, 1'b0);
        queue_request(20'd150, 1'b0);
        queue_request(20'd499, 1'b0);
        queue_request(20'd500, 1'b0);
        queue_request(20'd650, 1'b0);
        queue_request(20'd1999, 1'b0);
        queue_request(20'h80000, 1'b0);
        queue_request(ndg_pkg::AMOUNT_W'(vault_value(plan_vault) + 1), 1'b0);
        queue_request(20'hFFFFF, 1'b0);
        queue_request(20'd1234, 1'b1);

        // mostly everyday withdrawals, stock drains slowly
        for (int i = 0; i < 1200; i++)
        begin
            r = $urandom_range(99);
            if (r < 75)
                queue_request(ndg_pkg::AMOUNT_W'($urandom_range(1, 150)), i == 600);
            else if (r < 87)
                queue_request(ndg_pkg::AMOUNT_W'($urandom_range(1, 1000)), 1'b0);
            else if (r < 95)
                queue_request(ndg_pkg::AMOUNT_W'($urandom) | 20'h80000, 1'b0);
            else if (r < 97)
                queue_request(20'd0, 1'b0);
            else
                queue_request(ndg_pkg::AMOUNT_W'($urandom_range(1, 20)), 1'b0);
        end

        // amounts follow the balance down, so the stock thins out and gets sparse
        for (int i = 0; i < 550; i++)
        begin
            bal = vault_value(plan_vault);
            r = $urandom_range(99);
            if (r < 70)
                queue_request(ndg_pkg::AMOUNT_W'($urandom_range(1, bal / 16 + 3)), 1'b0);
            else if (r < 85)
                queue_request(ndg_pkg::AMOUNT_W'($urandom_range(1, bal + 3)), 1'b0);
            else if (r < 95)
                queue_request(ndg_pkg::AMOUNT_W'($urandom_range(1, 30)), 1'b0);
            else
                queue_request(ndg_pkg::AMOUNT_W'($urandom) | 20'h80000, 1'b0);
        end

        // whole remaining balance, then requests against an emptied stock
        queue_request(ndg_pkg::AMOUNT_W'(vault_value(plan_vault)), 1'b1);
        queue_request(20'd0, 1'b0);
        queue_request(20'd1, 1'b0);
        queue_request(20'hFFFFF, 1'b0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (request_q.size() != 0 || s_tvalid || payout_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (n_fail == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/ndg_pkg.sv
rtl/ndg_cell.sv
rtl/note_dispense_greedy.sv
tb/sv/tb_note_dispense_greedy.sv
